// ===== rtl/core/tgi_pkg.sv =====
// shared constants, types and register codes of the trilinear grid interpolator
package tgi_pkg;

  // grid axes are powers of two; their product must not exceed the store
  localparam int COL_LOG2 = 4;
  localparam int ROW_LOG2 = 4;
  localparam int LAY_LOG2 = 4;
  localparam int COLS     = 1 << COL_LOG2;
  localparam int ROWS     = 1 << ROW_LOG2;
  localparam int LAYERS   = 1 << LAY_LOG2;
  localparam int GRID_AW  = COL_LOG2 + ROW_LOG2 + LAY_LOG2;

  localparam int NUM_AXES = 3;
  localparam int AX_LON   = 0;
  localparam int AX_LAT   = 1;
  localparam int AX_DEPTH = 2;

  localparam int CELL_W = (COL_LOG2 > ROW_LOG2) ?
                          ((COL_LOG2 > LAY_LOG2) ? COL_LOG2 : LAY_LOG2) :
                          ((ROW_LOG2 > LAY_LOG2) ? ROW_LOG2 : LAY_LOG2);
  localparam int FRAC_W    = 16;
  localparam int ONE_FRAC  = 1 << FRAC_W;
  localparam int DIV_STEPS = CELL_W + FRAC_W;

  localparam int COORD_W = 32;
  localparam int OFF_W   = COORD_W + 1;
  localparam int SPC_W   = 31;
  localparam int VAL_W   = 32;
  localparam int LIM_W   = SPC_W + CELL_W;

  localparam int STORE_AW  = 12;
  localparam int NUM_BANKS = 8;
  localparam int BANK_SEL_W = 3;
  localparam int BANK_AW   = GRID_AW - BANK_SEL_W;
  localparam int BANK_DEPTH = 1 << BANK_AW;

  localparam logic [SPC_W-1:0] SPC_RESET = SPC_W'(1048576);

  localparam logic [CELL_W-1:0] AXIS_LAST [NUM_AXES] = '{
    CELL_W'(COLS - 1), CELL_W'(ROWS - 1), CELL_W'(LAYERS - 1)
  };

  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LON_ORIGIN,
    CFG_LON_SPACING,
    CFG_LAT_ORIGIN,
    CFG_LAT_SPACING,
    CFG_DEPTH_ORIGIN,
    CFG_DEPTH_SPACING
  } cfg_idx_t;

  localparam logic KIND_LOAD = 1'b0;

  typedef struct packed {
    logic [VAL_W-1:0]  origin;
    logic [SPC_W-1:0]  spacing;
    logic [LIM_W-1:0]  lim;
  } axis_cfg_t;

  typedef struct packed {
    logic                load;
    logic                outside;
    logic [STORE_AW-1:0] addr;
    logic [VAL_W-1:0]    value;
  } div_side_t;

  typedef struct packed {
    logic                  outside;
    logic [FRAC_W-1:0]     frac_col;
    logic [FRAC_W-1:0]     frac_row;
    logic [FRAC_W-1:0]     frac_lay;
    logic [BANK_SEL_W-1:0] par;
  } blend_side_t;

endpackage

// ===== rtl/core/tgi_ram.sv =====
// generic single-write, single-read ram with registered read data
module tgi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/tgi_cfg.sv =====
// configuration registers and per-axis range limits
module tgi_cfg import tgi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [VAL_W-1:0]         cfg_data,
  output axis_cfg_t [NUM_AXES-1:0] axis_cfg
);

  logic [VAL_W-1:0] origin_r  [NUM_AXES];
  logic [SPC_W-1:0] spacing_r [NUM_AXES];
  logic [LIM_W-1:0] lim_r     [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        origin_r[ax]  <= '0;
        spacing_r[ax] <= SPC_RESET;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LON_ORIGIN:    origin_r[AX_LON]    <= cfg_data;
        CFG_LON_SPACING:   spacing_r[AX_LON]   <= cfg_data[SPC_W-1:0];
        CFG_LAT_ORIGIN:    origin_r[AX_LAT]    <= cfg_data;
        CFG_LAT_SPACING:   spacing_r[AX_LAT]   <= cfg_data[SPC_W-1:0];
        CFG_DEPTH_ORIGIN:  origin_r[AX_DEPTH]  <= cfg_data;
        CFG_DEPTH_SPACING: spacing_r[AX_DEPTH] <= cfg_data[SPC_W-1:0];
        default: ;
      endcase
    end
  end

  // offset at or past this lands on or beyond the last grid point
  always_ff @(posedge clk) begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      lim_r[ax] <= LIM_W'(spacing_r[ax]) * LIM_W'(AXIS_LAST[ax]);
    end
  end

  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      axis_cfg[ax].origin  = origin_r[ax];
      axis_cfg[ax].spacing = spacing_r[ax];
      axis_cfg[ax].lim     = lim_r[ax];
    end
  end

endmodule

// ===== rtl/core/tgi_div.sv =====
// pipelined restoring divider: cell index then fraction bits, one bit per stage
module tgi_div import tgi_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [OFF_W-1:0]  off,
  input  logic [SPC_W-1:0]  spacing,
  output logic [CELL_W-1:0] cell_idx,
  output logic [FRAC_W-1:0] frac
);

  localparam int XW = OFF_W + CELL_W + 1;

  logic [OFF_W-1:0]     rem_r [1:DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_r [1:DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [OFF_W-1:0]     rem_src;
    logic [DIV_STEPS-1:0] quo_src;
    logic [XW-1:0]        r_in;
    logic [XW-1:0]        d_in;
    logic [XW-1:0]        diff;
    logic                 take;

    if (k == 0) begin : g_first
      assign rem_src = off;
      assign quo_src = '0;
    end else begin : g_next
      assign rem_src = rem_r[k];
      assign quo_src = quo_r[k];
    end

    // integer bits compare against shifted divisor, fraction bits shift remainder
    if (k < CELL_W) begin : g_int
      assign r_in = XW'(rem_src);
      assign d_in = XW'(spacing) << (CELL_W - 1 - k);
    end else begin : g_frac
      assign r_in = XW'(rem_src) << 1;
      assign d_in = XW'(spacing);
    end

    assign take = (r_in >= d_in);
    assign diff = r_in - d_in;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= take ? diff[OFF_W-1:0] : r_in[OFF_W-1:0];
        quo_r[k+1] <= {quo_src[DIV_STEPS-2:0], take};
      end
    end
  end

  assign cell_idx = quo_r[DIV_STEPS][DIV_STEPS-1 -: CELL_W];
  assign frac     = quo_r[DIV_STEPS][FRAC_W-1:0];

endmodule

// ===== rtl/core/tgi_blend.sv =====
// two-stage linear blend of two q24.8 values with a 16-bit weight
module tgi_blend import tgi_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [VAL_W-1:0]  lo,
  input  logic [VAL_W-1:0]  hi,
  input  logic [FRAC_W-1:0] frac,
  output logic [VAL_W-1:0]  mix
);

  localparam int WT_W   = FRAC_W + 2;
  localparam int PROD_W = VAL_W + WT_W;
  localparam int SUM_W  = PROD_W + 1;

  logic signed [WT_W-1:0]   w_hi;
  logic signed [WT_W-1:0]   w_lo;
  logic signed [PROD_W-1:0] p_lo_r;
  logic signed [PROD_W-1:0] p_hi_r;
  logic signed [SUM_W-1:0]  sum;
  logic [VAL_W-1:0]         mix_r;

  assign w_hi = $signed(WT_W'(frac));
  assign w_lo = $signed(WT_W'(ONE_FRAC)) - w_hi;

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo_r <= $signed(lo) * w_lo;
      p_hi_r <= $signed(hi) * w_hi;
    end
  end

  // round half up, then floor by dropping the fraction bits
  assign sum = SUM_W'(p_lo_r) + SUM_W'(p_hi_r) + $signed(SUM_W'(ONE_FRAC / 2));

  always_ff @(posedge clk) begin
    if (en) begin
      mix_r <= sum[FRAC_W +: VAL_W];
    end
  end

  assign mix = mix_r;

endmodule

// ===== rtl/core/trilinear_grid_interpolator.sv =====
// top level: trilinear interpolation over a banked 3d grid store
//
// input channel (in_valid/in_ready) takes one beat per cycle. a beat with
// in_kind == load writes in_grid_value at in_grid_address and gives no
// result; a query beat carries lon/lat/depth and gives one result beat on
// the out channel (out_valid/out_ready): out_interp_value and out_outside.
// the cfg port writes origin and spacing registers, taken in the cycle of
// cfg_we; write them only while the pipeline is empty.
// a query passes through the input capture stage, the offset stage, one
// divider stage per quotient bit (cell index and 16 fraction bits), the
// store read, and three blend levels of two stages each. throughput is
// one beat per cycle, since the eight corners come from eight ram banks
// chosen by index parity. when the receiver stalls the whole pipeline
// freezes in place and in_ready drops; the output register holds its
// beat. reset clears the valid bits, zeroes the origins and sets the
// spacings to SPC_RESET; grid contents are undefined until loaded.
module trilinear_grid_interpolator import tgi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [STORE_AW-1:0]  in_grid_address,
  input  logic [VAL_W-1:0]     in_grid_value,
  input  logic [COORD_W-1:0]   in_query_lon,
  input  logic [COORD_W-1:0]   in_query_lat,
  input  logic [COORD_W-1:0]   in_query_depth,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VAL_W-1:0]     out_interp_value,
  output logic                 out_outside
);

  localparam int CMP_W    = (LIM_W > OFF_W) ? LIM_W : OFF_W;
  localparam int BL_DEPTH = 6;

  axis_cfg_t [NUM_AXES-1:0] axis_cfg;
  logic adv;

  tgi_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .axis_cfg  (axis_cfg)
  );

  // stage a: captured beat
  logic                a_valid_r;
  logic                a_load_r;
  logic [STORE_AW-1:0] a_addr_r;
  logic [VAL_W-1:0]    a_value_r;
  logic [COORD_W-1:0]  a_coord_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_load_r            <= (in_kind == KIND_LOAD);
      a_addr_r            <= in_grid_address;
      a_value_r           <= in_grid_value;
      a_coord_r[AX_LON]   <= in_query_lon;
      a_coord_r[AX_LAT]   <= in_query_lat;
      a_coord_r[AX_DEPTH] <= in_query_depth;
    end
  end

  // stage b: offsets from the origins
  logic                b_valid_r;
  logic                b_load_r;
  logic [STORE_AW-1:0] b_addr_r;
  logic [VAL_W-1:0]    b_value_r;
  logic [OFF_W-1:0]    b_off_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_load_r  <= a_load_r;
      b_addr_r  <= a_addr_r;
      b_value_r <= a_value_r;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        b_off_r[ax] <= {a_coord_r[ax][COORD_W-1], a_coord_r[ax]}
                     - {axis_cfg[ax].origin[VAL_W-1], axis_cfg[ax].origin};
      end
    end
  end

  // range check, then into the divider pipes
  logic [NUM_AXES-1:0] bad;
  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      bad[ax] = b_off_r[ax][OFF_W-1] || (axis_cfg[ax].spacing == '0) ||
                (CMP_W'(b_off_r[ax]) >= CMP_W'(axis_cfg[ax].lim));
    end
  end

  logic [CELL_W-1:0] cell_idx [NUM_AXES];
  logic [FRAC_W-1:0] frac [NUM_AXES];

  for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_div
    tgi_div u_div (
      .clk      (clk),
      .en       (adv),
      .off      (b_off_r[ax]),
      .spacing  (axis_cfg[ax].spacing),
      .cell_idx (cell_idx[ax]),
      .frac     (frac[ax])
    );
  end

  logic      dv_r [1:DIV_STEPS];
  div_side_t ds_r [1:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= DIV_STEPS; k++) begin
        dv_r[k] <= 1'b0;
      end
    end else if (adv) begin
      dv_r[1] <= b_valid_r;
      for (int k = 2; k <= DIV_STEPS; k++) begin
        dv_r[k] <= dv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds_r[1].load    <= b_load_r;
      ds_r[1].outside <= |bad;
      ds_r[1].addr    <= b_addr_r;
      ds_r[1].value   <= b_value_r;
      for (int k = 2; k <= DIV_STEPS; k++) begin
        ds_r[k] <= ds_r[k-1];
      end
    end
  end

  // stage d: bank addresses for the eight corners, or the load's bank
  logic      d_valid;
  div_side_t d_side;
  assign d_valid = dv_r[DIV_STEPS];
  assign d_side  = ds_r[DIV_STEPS];

  logic [COL_LOG2-1:0] ld_col;
  logic [ROW_LOG2-1:0] ld_row;
  logic [LAY_LOG2-1:0] ld_lay;
  logic [BANK_AW-1:0]  ld_baddr;
  logic [BANK_SEL_W-1:0] ld_bank;
  logic                ld_in_grid;

  assign ld_col = d_side.addr[COL_LOG2-1:0];
  assign ld_row = d_side.addr[COL_LOG2 +: ROW_LOG2];
  assign ld_lay = d_side.addr[COL_LOG2+ROW_LOG2 +: LAY_LOG2];
  assign ld_baddr = {ld_lay[LAY_LOG2-1:1], ld_row[ROW_LOG2-1:1], ld_col[COL_LOG2-1:1]};
  assign ld_bank  = {ld_lay[0], ld_row[0], ld_col[0]};
  // entries past the grid are never read back
  assign ld_in_grid = ((STORE_AW+1)'(d_side.addr) >> GRID_AW) == '0;

  logic [COL_LOG2-1:0] q_col;
  logic [ROW_LOG2-1:0] q_row;
  logic [LAY_LOG2-1:0] q_lay;
  assign q_col = cell_idx[AX_LON][COL_LOG2-1:0];
  assign q_row = cell_idx[AX_LAT][ROW_LOG2-1:0];
  assign q_lay = cell_idx[AX_DEPTH][LAY_LOG2-1:0];

  logic [NUM_BANKS-1:0] bank_we;
  logic [VAL_W-1:0]     bank_rdata [NUM_BANKS];

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [COL_LOG2-1:0] cc;
    logic [ROW_LOG2-1:0] rc;
    logic [LAY_LOG2-1:0] lc;
    logic [BANK_AW-1:0]  raddr;

    // pick whichever of index and index+1 has this bank's parity
    assign cc = q_col + COL_LOG2'(q_col[0] ^ b[0]);
    assign rc = q_row + ROW_LOG2'(q_row[0] ^ b[1]);
    assign lc = q_lay + LAY_LOG2'(q_lay[0] ^ b[2]);
    assign raddr = {lc[LAY_LOG2-1:1], rc[ROW_LOG2-1:1], cc[COL_LOG2-1:1]};
    assign bank_we[b] = adv && d_valid && d_side.load && ld_in_grid &&
                        (ld_bank == BANK_SEL_W'(b));

    tgi_ram #(
      .WIDTH (VAL_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (ld_baddr),
      .wdata (d_side.value),
      .re    (adv),
      .raddr (raddr),
      .rdata (bank_rdata[b])
    );
  end

  // stages e..k: blend tree; index 0 lines up with the ram read data
  logic        bv_r [0:BL_DEPTH];
  blend_side_t bs_r [0:BL_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= BL_DEPTH; k++) begin
        bv_r[k] <= 1'b0;
      end
    end else if (adv) begin
      bv_r[0] <= d_valid && !d_side.load;
      for (int k = 1; k <= BL_DEPTH; k++) begin
        bv_r[k] <= bv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bs_r[0].outside  <= d_side.outside;
      bs_r[0].frac_col <= frac[AX_LON];
      bs_r[0].frac_row <= frac[AX_LAT];
      bs_r[0].frac_lay <= frac[AX_DEPTH];
      bs_r[0].par      <= {q_lay[0], q_row[0], q_col[0]};
      for (int k = 1; k <= BL_DEPTH; k++) begin
        bs_r[k] <= bs_r[k-1];
      end
    end
  end

  logic [VAL_W-1:0] v_mix [2][2];
  logic [VAL_W-1:0] w_mix [2];
  logic [VAL_W-1:0] res_mix;

  for (genvar dl = 0; dl < 2; dl++) begin : g_lay
    for (genvar dr = 0; dr < 2; dr++) begin : g_row
      logic [BANK_SEL_W-1:0] sel_lo;
      logic [BANK_SEL_W-1:0] sel_hi;
      assign sel_lo = bs_r[0].par ^ BANK_SEL_W'((dl << 2) | (dr << 1));
      assign sel_hi = bs_r[0].par ^ BANK_SEL_W'((dl << 2) | (dr << 1) | 1);

      tgi_blend u_col (
        .clk  (clk),
        .en   (adv),
        .lo   (bank_rdata[sel_lo]),
        .hi   (bank_rdata[sel_hi]),
        .frac (bs_r[0].frac_col),
        .mix  (v_mix[dr][dl])
      );
    end

    tgi_blend u_row (
      .clk  (clk),
      .en   (adv),
      .lo   (v_mix[0][dl]),
      .hi   (v_mix[1][dl]),
      .frac (bs_r[2].frac_row),
      .mix  (w_mix[dl])
    );
  end

  tgi_blend u_lay (
    .clk  (clk),
    .en   (adv),
    .lo   (w_mix[0]),
    .hi   (w_mix[1]),
    .frac (bs_r[4].frac_lay),
    .mix  (res_mix)
  );

  // the last blend register is the output register
  assign adv              = !bv_r[BL_DEPTH] || out_ready;
  assign in_ready         = adv;
  assign out_valid        = bv_r[BL_DEPTH];
  assign out_outside      = bs_r[BL_DEPTH].outside;
  assign out_interp_value = bs_r[BL_DEPTH].outside ? '0 : res_mix;

  a_accept_captured: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> a_valid_r)
    else $error("accepted beat not captured");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> (bv_r[0] == $past(bv_r[0])) && (dv_r[DIV_STEPS] == $past(dv_r[DIV_STEPS])))
    else $error("pipeline moved during stall");

  a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bank_we))
    else $error("load wrote more than one bank");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv && d_valid && d_side.load |=> !bv_r[0])
    else $error("load produced a result");

endmodule

// ===== tb/trilinear_grid_interpolator_tb.sv =====
// testbench for the trilinear grid interpolator: randomized beats checked against a predictor
`timescale 1ns / 1ps

module trilinear_grid_interpolator_tb;
  import tgi_pkg::*;

  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int DRAIN_CYCLES = 40;
  localparam int FILL_SPAN = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = {CFG_IDX_W{1'b1}};
  localparam logic KIND_QUERY = ~KIND_LOAD;
  localparam int AXIS_SIZE [NUM_AXES] = '{COLS, ROWS, LAYERS};

  typedef struct {
    logic [VAL_W-1:0] value;
    logic             outside;
  } interp_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_kind;
  logic [STORE_AW-1:0]  in_grid_address;
  logic [VAL_W-1:0]     in_grid_value;
  logic [COORD_W-1:0]   in_query_lon;
  logic [COORD_W-1:0]   in_query_lat;
  logic [COORD_W-1:0]   in_query_depth;
  logic                 out_valid;
  logic                 out_ready;
  logic [VAL_W-1:0]     out_interp_value;
  logic                 out_outside;

  trilinear_grid_interpolator uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_grid_address(in_grid_address), .in_grid_value(in_grid_value),
    .in_query_lon(in_query_lon), .in_query_lat(in_query_lat),
    .in_query_depth(in_query_depth),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_interp_value(out_interp_value), .out_outside(out_outside)
  );

  // predictor state
  longint         axis_origin [NUM_AXES];
  longint         axis_spacing [NUM_AXES];
  logic [VAL_W-1:0] grid_mirror [STORE_DEPTH];
  interp_result_t expected_results [$];

  int  mismatches;
  int  n_loads, n_queries, n_outside, n_checked;
  bit  gap_en;
  int  burst_left;
  int  stall_mode;
  int  hold_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit locate_cell(int ax, logic [COORD_W-1:0] coord,
                                     output int cell_idx, output longint frac);
    longint off;
    longint q;
    off = longint'($signed(coord)) - axis_origin[ax];
    cell_idx = 0;
    frac = 0;
    if (axis_spacing[ax] == 0 || off < 0) return 1'b0;
    q = off / axis_spacing[ax];
    if (q >= AXIS_SIZE[ax] - 1) return 1'b0;
    cell_idx = int'(q);
    frac = ((off - q * axis_spacing[ax]) << FRAC_W) / axis_spacing[ax];
    return 1'b1;
  endfunction

  // arithmetic shift of a signed longint is a floor
  function automatic longint lerp_q16(longint lo, longint hi, longint f);
    return (lo * (ONE_FRAC - f) + hi * f + 32768) >>> FRAC_W;
  endfunction

  function automatic longint grid_at(int addr);
    return longint'($signed(grid_mirror[addr % STORE_DEPTH]));
  endfunction

  function automatic interp_result_t interpolate(logic [COORD_W-1:0] lon,
      logic [COORD_W-1:0] lat, logic [COORD_W-1:0] dep);
    interp_result_t r;
    int c, rw, l, base, plane;
    longint fc, fr, fl, v00, v10, v01, v11, w0, w1;
    r.value = '0;
    r.outside = 1'b1;
    if (!locate_cell(AX_LON, lon, c, fc) || !locate_cell(AX_LAT, lat, rw, fr) ||
        !locate_cell(AX_DEPTH, dep, l, fl)) return r;
    plane = COLS * ROWS;
    base = (l * ROWS + rw) * COLS + c;
    v00 = lerp_q16(grid_at(base), grid_at(base + 1), fc);
    v10 = lerp_q16(grid_at(base + COLS), grid_at(base + COLS + 1), fc);
    v01 = lerp_q16(grid_at(base + plane), grid_at(base + plane + 1), fc);
    v11 = lerp_q16(grid_at(base + plane + COLS), grid_at(base + plane + COLS + 1), fc);
    w0 = lerp_q16(v00, v10, fr);
    w1 = lerp_q16(v01, v11, fr);
    r.value = VAL_W'(lerp_q16(w0, w1, fl));
    r.outside = 1'b0;
    return r;
  endfunction

  // coordinate landing in a chosen cell; falls back to the axis origin if it cannot fit
  function automatic logic [COORD_W-1:0] coord_in_cell(int ax, int cell_idx, longint rem);
    longint c;
    c = axis_origin[ax] + longint'(cell_idx) * axis_spacing[ax] + rem;
    if (c < -(64'sd1 <<< 31) || c >= (64'sd1 <<< 31)) return COORD_W'(axis_origin[ax]);
    return COORD_W'(c);
  endfunction

  function automatic logic [COORD_W-1:0] random_inside(int ax);
    longint rem;
    rem = (axis_spacing[ax] > 0) ? longint'($urandom) % axis_spacing[ax] : 0;
    return coord_in_cell(ax, $urandom_range(0, FILL_SPAN - 2), rem);
  endfunction

  // raw coordinate; one that would land beyond the filled corner goes to the origin
  function automatic logic [COORD_W-1:0] raw_coord(int ax);
    logic [COORD_W-1:0] c;
    int idx;
    longint f;
    c = $urandom;
    if (locate_cell(ax, c, idx, f) && idx > FILL_SPAN - 2) return COORD_W'(axis_origin[ax]);
    return c;
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(VAL_W-1){1'b1}}};
      1: return {1'b1, {(VAL_W-1){1'b0}}};
      2: return VAL_W'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(logic kind, logic [STORE_AW-1:0] addr, logic [VAL_W-1:0] value,
                           logic [COORD_W-1:0] lon, logic [COORD_W-1:0] lat,
                           logic [COORD_W-1:0] dep);
    if (gap_en && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_grid_address <= addr;
    in_grid_value   <= value;
    in_query_lon    <= lon;
    in_query_lat    <= lat;
    in_query_depth  <= dep;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) burst_left--;
    if (kind == KIND_LOAD) begin
      grid_mirror[addr] = value;
      n_loads++;
    end else begin
      expected_results.push_back(interpolate(lon, lat, dep));
      n_queries++;
    end
  endtask

  task automatic load_beat(int addr, logic [VAL_W-1:0] value);
    send_beat(KIND_LOAD, STORE_AW'(addr), value, $urandom, $urandom, $urandom);
  endtask

  task automatic query_beat(logic [COORD_W-1:0] lon, logic [COORD_W-1:0] lat,
                            logic [COORD_W-1:0] dep);
    send_beat(KIND_QUERY, STORE_AW'($urandom), $urandom, lon, lat, dep);
  endtask

  // the eight corners of one cell
  task automatic load_block(int c, int r, int l);
    for (int dl = 0; dl < 2; dl++)
      for (int dr = 0; dr < 2; dr++)
        for (int dc = 0; dc < 2; dc++)
          load_beat(((l + dl) * ROWS + r + dr) * COLS + c + dc, random_value());
  endtask

  task automatic random_beat();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25)
      load_beat($urandom_range(0, STORE_DEPTH - 1), random_value());
    else if (pick < 85)
      query_beat(random_inside(AX_LON), random_inside(AX_LAT), random_inside(AX_DEPTH));
    else
      query_beat(raw_coord(AX_LON), raw_coord(AX_LAT), raw_coord(AX_DEPTH));
  endtask

  // loads give no result, so after the last result let the pipe empty out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LON_ORIGIN:    axis_origin[AX_LON]    = longint'($signed(data));
      CFG_LAT_ORIGIN:    axis_origin[AX_LAT]    = longint'($signed(data));
      CFG_DEPTH_ORIGIN:  axis_origin[AX_DEPTH]  = longint'($signed(data));
      CFG_LON_SPACING:   axis_spacing[AX_LON]   = longint'(data[SPC_W-1:0]);
      CFG_LAT_SPACING:   axis_spacing[AX_LAT]   = longint'(data[SPC_W-1:0]);
      CFG_DEPTH_SPACING: axis_spacing[AX_DEPTH] = longint'(data[SPC_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_axes(logic [VAL_W-1:0] lon_o, logic [VAL_W-1:0] lon_s,
                          logic [VAL_W-1:0] lat_o, logic [VAL_W-1:0] lat_s,
                          logic [VAL_W-1:0] dep_o, logic [VAL_W-1:0] dep_s);
    wait_idle();
    write_reg(CFG_LON_ORIGIN, lon_o);
    write_reg(CFG_LON_SPACING, lon_s);
    write_reg(CFG_LAT_ORIGIN, lat_o);
    write_reg(CFG_LAT_SPACING, lat_s);
    write_reg(CFG_DEPTH_ORIGIN, dep_o);
    write_reg(CFG_DEPTH_SPACING, dep_s);
  endtask

  // random queries stay in this low corner, so none reads an unwritten entry
  task automatic test_fill_grid();
    gap_en = 1'b0;
    for (int l = 0; l < FILL_SPAN; l++)
      for (int r = 0; r < FILL_SPAN; r++)
        for (int c = 0; c < FILL_SPAN; c++)
          load_beat((l * ROWS + r) * COLS + c, random_value());
  endtask

  task automatic test_directed();
    longint one;
    one = axis_spacing[AX_LON];
    load_beat(0, {1'b0, {(VAL_W-1){1'b1}}});
    load_beat(1, {1'b1, {(VAL_W-1){1'b0}}});
    load_beat(COLS, '1);
    load_beat(COLS * ROWS, '0);
    load_block(COLS - 2, 0, 0);
    load_block(COLS - 2, ROWS - 2, LAYERS - 2);
    // exact grid point, midpoints, and just below the next point
    query_beat('0, '0, '0);
    query_beat(COORD_W'(one / 2), '0, '0);
    query_beat(COORD_W'(one - 1), COORD_W'(one / 2), COORD_W'(one / 3));
    query_beat(COORD_W'(one / 2), COORD_W'(one / 2), COORD_W'(one / 2));
    // last inside cell on lon, and first index past it on each axis
    query_beat(coord_in_cell(AX_LON, COLS - 2, one - 1), '0, '0);
    query_beat(coord_in_cell(AX_LON, COLS - 1, 0), '0, '0);
    query_beat('0, coord_in_cell(AX_LAT, ROWS - 1, 0), '0);
    query_beat('0, '0, coord_in_cell(AX_DEPTH, LAYERS - 1, 0));
    // negative offsets and coordinate extremes
    query_beat('1, '0, '0);
    query_beat('0, '0, {1'b1, {(COORD_W-1){1'b0}}});
    query_beat({1'b0, {(COORD_W-1){1'b1}}}, '0, '0);
    query_beat({1'b1, {(COORD_W-1){1'b0}}}, '1, '1);
    load_beat(STORE_DEPTH - 1, random_value());
    query_beat(coord_in_cell(AX_LON, COLS - 2, one / 2),
               coord_in_cell(AX_LAT, ROWS - 2, one / 2),
               coord_in_cell(AX_DEPTH, LAYERS - 2, one / 2));
    // unknown register index must change nothing
    wait_idle();
    write_reg(CFG_UNUSED, 32'h0000_0001);
    query_beat(COORD_W'(one / 4), COORD_W'(one / 4), COORD_W'(one / 4));
  endtask

  task automatic test_random(int count, bit gaps, int mode);
    gap_en = gaps;
    stall_mode = mode;
    for (int i = 0; i < count; i++) random_beat();
  endtask

  task automatic test_backpressure();
    gap_en = 1'b0;
    stall_mode = 0;
    hold_cycles = 300;
    for (int i = 0; i < 80; i++)
      query_beat(random_inside(AX_LON), random_inside(AX_LAT), random_inside(AX_DEPTH));
  endtask

  task automatic test_config_sweep();
    set_axes(32'hFF80_0000, 32'h0008_0000, 32'h0010_0000, 32'h0020_0000,
             32'hFFF0_0000, 32'h0000_1000);
    test_random(100, 1'b1, 1);
    set_axes({1'b1, 31'd0}, 32'h0000_0001, 32'h7FFF_FFF0, 32'h0000_0001,
             32'h0000_0000, 32'h0000_0003);
    test_random(100, 1'b0, 2);
    set_axes({1'b1, 31'd0}, 32'h7FFF_FFFF, {1'b1, 31'd0}, 32'hFFFF_FFFF,
             32'h8000_0001, 32'h4000_0000);
    test_random(100, 1'b1, 2);
  endtask

  // spacing of zero cannot divide, every query lands outside
  task automatic test_zero_spacing();
    set_axes(32'h0, 32'h0010_0000, 32'h0, 32'h0000_0000, 32'h0, 32'h0010_0000);
    test_random(40, 1'b1, 1);
    set_axes(32'h0, 32'h8000_0000, 32'h0, 32'h0010_0000, 32'h0, 32'h0010_0000);
    test_random(40, 1'b0, 0);
  endtask

  // receiver stalls
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 9) < 7);
          default: out_ready <= (($urandom_range(0, 15) & 4'b1100) != 4'b1100);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    interp_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with none expected: value=%h outside=%b",
               out_interp_value, out_outside);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        n_checked++;
        if (exp_r.outside) n_outside++;
        if (out_outside !== exp_r.outside) begin
          $error("outside: expected %b, got %b", exp_r.outside, out_outside);
          mismatches++;
        end
        if (out_interp_value !== exp_r.value) begin
          $error("interp_value: expected %h, got %h", exp_r.value, out_interp_value);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_kind <= KIND_LOAD;
    in_grid_address <= '0;
    in_grid_value <= '0;
    in_query_lon <= '0;
    in_query_lat <= '0;
    in_query_depth <= '0;
    mismatches = 0;
    n_loads = 0;
    n_queries = 0;
    n_outside = 0;
    n_checked = 0;
    gap_en = 1'b0;
    burst_left = 0;
    stall_mode = 0;
    hold_cycles = 0;
    for (int a = 0; a < NUM_AXES; a++) begin
      axis_origin[a] = 0;
      axis_spacing[a] = longint'(SPC_RESET);
    end
    for (int a = 0; a < STORE_DEPTH; a++) grid_mirror[a] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_grid();
    test_directed();
    test_random(200, 1'b1, 1);
    test_backpressure();
    test_random(80, 1'b0, 0);
    test_config_sweep();
    test_zero_spacing();
    set_axes(32'h0, 32'h0010_0000, 32'h0, 32'h0010_0000, 32'h0, 32'h0010_0000);
    test_random(100, 1'b1, 2);

    wait_idle();
    $display("run: %0d loads, %0d queries; %0d results checked, %0d of them outside",
             n_loads, n_queries, n_checked, n_outside);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== trilinear_grid_interpolator.f =====
rtl/core/tgi_pkg.sv
rtl/core/tgi_ram.sv
rtl/core/tgi_cfg.sv
rtl/core/tgi_div.sv
rtl/core/tgi_blend.sv
rtl/core/trilinear_grid_interpolator.sv
tb/trilinear_grid_interpolator_tb.sv
